// ===== hdl/qsnu_pkg.sv =====
// qsnu_pkg: types, codes and sizes shared by the quadratic surface neighbor update unit
// no dependencies; imported by qsnu_coef_mem, qsnu_mac and the top level
package qsnu_pkg;

   localparam int MATRIX_DIM     = 6;
   localparam int NEIGHBOR_COUNT = 4;
   localparam int COEF_ROWS      = NEIGHBOR_COUNT * MATRIX_DIM;
   localparam int COEF_DEPTH     = COEF_ROWS * MATRIX_DIM;
   localparam int ROW_W          = $clog2(COEF_ROWS);
   localparam int LANE_W         = $clog2(MATRIX_DIM);
   localparam int WORD_W         = 32;
   localparam int PROD_W         = 2 * WORD_W;
   localparam int RND_W          = PROD_W - 16;
   localparam int SUM_W          = RND_W + 3;
   localparam int ACC_W          = 64;
   localparam int CSR_IDX_W      = 2;

   // coefficient address split: row = (idx * 171) >> 10 is exact for 8-bit idx
   localparam int DIV6_MUL   = 171;
   localparam int DIV6_SHIFT = 10;

   typedef enum logic [1:0] {
      MODE_LOAD     = 2'd0,
      MODE_CENTER   = 2'd1,
      MODE_NEIGHBOR = 2'd2
   } mode_type;

   localparam logic [1:0] BREAK_NONE      = 2'd0;
   localparam logic [1:0] BREAK_THRESHOLD = 2'd1;
   localparam logic [1:0] BREAK_LABEL     = 2'd2;

   localparam logic [1:0] DIR_SOUTH = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_THRESHOLD = 2'd1;

   typedef logic [WORD_W-1:0]            word_type;
   typedef word_type [MATRIX_DIM-1:0]    vec_type;
   typedef logic signed [ACC_W-1:0]      acc_type;
   typedef acc_type [MATRIX_DIM-1:0]     acc_vec_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [1:0]         direction;
      logic [7:0]         coef_index;
      logic signed [31:0] val_z;
      logic signed [31:0] val_a;
      logic signed [31:0] val_b;
      logic signed [31:0] val_c;
      logic signed [31:0] val_d;
      logic signed [31:0] val_e;
      logic [7:0]         region_label;
      logic [11:0]        col;
      logic [11:0]        row;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_z;
      logic signed [31:0] new_a;
      logic signed [31:0] new_b;
      logic signed [31:0] new_c;
      logic signed [31:0] new_d;
      logic signed [31:0] new_e;
      logic [11:0]        col_out;
      logic [11:0]        row_out;
   } rsp_type;

   // tag that travels with one matrix row through the multiply pipeline
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [LANE_W-1:0] lane;
      logic              clear;
   } mac_ctrl_type;

   function automatic logic [WORD_W-1:0] sat32(input acc_type v);
      logic upper_ones;
      logic upper_zeros;
      upper_ones  = &v[ACC_W-1:WORD_W-1];
      upper_zeros = ~|v[ACC_W-1:WORD_W-1];
      if (upper_ones || upper_zeros) begin
         return v[WORD_W-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

endpackage

// ===== hdl/qsnu_coef_mem.sv =====
// qsnu_coef_mem: coefficient store, one bank per matrix column, a whole row read per cycle
// depends on qsnu_pkg
module qsnu_coef_mem
   import qsnu_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ROW_W-1:0]  wr_row,
   input  logic [LANE_W-1:0] wr_col,
   input  word_type          wr_data,
   input  logic              rd_en,
   input  logic [ROW_W-1:0]  rd_row,
   output vec_type           rd_data
);

   for (genvar c = 0; c < MATRIX_DIM; c++) begin : g_bank
      word_type bank [COEF_ROWS];

      always_ff @(posedge clock) begin
         if (wr_en && wr_col == LANE_W'(c)) begin
            bank[wr_row] <= wr_data;
         end
         if (rd_en) begin
            rd_data[c] <= bank[rd_row];
         end
      end
   end

endmodule

// ===== hdl/qsnu_mac.sv =====
// qsnu_mac: six parallel multipliers, rounding adder tree and the six row accumulators
// depends on qsnu_pkg; fed one coefficient row per cycle from qsnu_coef_mem
module qsnu_mac
   import qsnu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mac_ctrl_type ctrl,
   input  vec_type      coef_row,
   input  vec_type      vec,
   output acc_vec_type  acc,
   output logic         done
);

   logic signed [PROD_W-1:0] prod_in [MATRIX_DIM];
   logic signed [PROD_W-1:0] prod_ff [MATRIX_DIM];
   logic                     prod_vld_ff;
   logic                     prod_last_ff;
   logic [LANE_W-1:0]        prod_lane_ff;

   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     sum_vld_ff;
   logic                     sum_last_ff;
   logic [LANE_W-1:0]        sum_lane_ff;

   acc_vec_type              acc_ff;

   always_comb begin
      for (int j = 0; j < MATRIX_DIM; j++) begin
         prod_in[j] = $signed(coef_row[j]) * $signed(vec[j]);
      end
   end

   // round half up: add 2^15 then floor shift by 16
   always_comb begin
      logic signed [PROD_W-1:0] biased;
      sum_in = '0;
      for (int j = 0; j < MATRIX_DIM; j++) begin
         biased = prod_ff[j] + PROD_W'(32768);
         sum_in = sum_in + SUM_W'($signed(biased[PROD_W-1:16]));
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MATRIX_DIM; j++) begin
         prod_ff[j] <= prod_in[j];
      end
      prod_lane_ff <= ctrl.lane;
      prod_last_ff <= ctrl.last;
      sum_ff       <= sum_in;
      sum_lane_ff  <= prod_lane_ff;
      sum_last_ff  <= prod_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= ctrl.valid;
         sum_vld_ff  <= prod_vld_ff;
         for (int i = 0; i < MATRIX_DIM; i++) begin
            if (ctrl.clear) begin
               acc_ff[i] <= '0;
            end else if (sum_vld_ff && sum_lane_ff == LANE_W'(i)) begin
               acc_ff[i] <= acc_ff[i] - ACC_W'(sum_ff);
            end
         end
      end
   end

   assign acc  = acc_ff;
   assign done = sum_vld_ff & sum_last_ff;

endmodule

// ===== hdl/quadratic_surface_neighbor_update_unit.sv =====
// quadratic_surface_neighbor_update_unit: per-pixel quadratic surface relaxation step
// coefficient load and center requests leave busy low; a neighbor request holds busy while
// each matrix row is read from the coefficient store and passes the multiply, round/sum and
// accumulate stages, and for south while the result is emitted; only south emits a result,
// which strobes rsp_valid and cannot be held off by the receiver
// synchronous reset clears control registers, center state and accumulators, not coefficients
module quadratic_surface_neighbor_update_unit
   import qsnu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   state_type         state_ff, state_in;
   logic [LANE_W-1:0] cnt_ff;
   logic [1:0]        dir_ff;
   logic [1:0]        break_mode_ff;
   logic [30:0]       break_threshold_ff;
   vec_type           center_ff;
   logic [7:0]        center_label_ff;
   logic [11:0]       center_col_ff;
   logic [11:0]       center_row_ff;
   vec_type           vec_ff;
   logic              rd_vld_ff;
   logic              rd_last_ff;
   logic [LANE_W-1:0] rd_lane_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              accept;
   logic              take_load;
   logic              take_center;
   logic              take_neighbor;
   logic              issue;
   logic              emit;
   logic              done;
   logic              use_center;
   vec_type           req_vec;
   vec_type           coef_row;
   acc_vec_type       acc;
   mac_ctrl_type      mac_ctrl;
   logic [15:0]       idx_scaled;
   logic [ROW_W-1:0]  wr_row;
   logic [LANE_W-1:0] wr_col;
   logic [ROW_W-1:0]  rd_row;
   logic signed [32:0] z_diff;
   logic [32:0]       z_abs;

   assign accept        = start & ~busy;
   assign take_load     = accept && req_data.mode == MODE_LOAD
                          && req_data.coef_index < 8'(COEF_DEPTH);
   assign take_center   = accept && req_data.mode == MODE_CENTER;
   assign take_neighbor = accept && req_data.mode == MODE_NEIGHBOR;

   assign req_vec = {req_data.val_e, req_data.val_d, req_data.val_c,
                     req_data.val_b, req_data.val_a, req_data.val_z};

   // neighbor break test against the stored center
   always_comb begin
      z_diff = 33'($signed(center_ff[0])) - 33'(req_data.val_z);
      z_abs  = z_diff[32] ? 33'(-z_diff) : 33'(z_diff);
      case (break_mode_ff)
         BREAK_THRESHOLD: use_center = z_abs > 33'(break_threshold_ff);
         BREAK_LABEL:     use_center = req_data.region_label != center_label_ff;
         default:         use_center = 1'b0;
      endcase
   end

   // flat index to row and column without a divider
   assign idx_scaled = 16'(req_data.coef_index) * 16'(DIV6_MUL);
   assign wr_row     = ROW_W'(idx_scaled >> DIV6_SHIFT);
   assign wr_col     = LANE_W'(req_data.coef_index - 8'(wr_row) * 8'(MATRIX_DIM));
   assign rd_row     = ROW_W'(dir_ff) * ROW_W'(MATRIX_DIM) + ROW_W'(cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (take_neighbor) state_in = ST_ISSUE;
         ST_ISSUE: if (cnt_ff == LANE_W'(MATRIX_DIM - 1)) state_in = ST_DRAIN;
         ST_DRAIN: if (done) state_in = (dir_ff == DIR_SOUTH) ? ST_EMIT : ST_IDLE;
         ST_EMIT:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy  = 1'b1;
      issue = 1'b0;
      emit  = 1'b0;
      case (state_ff)
         ST_IDLE:  busy  = 1'b0;
         ST_ISSUE: issue = 1'b1;
         ST_EMIT:  emit  = 1'b1;
         default:  busy  = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         cnt_ff             <= '0;
         break_mode_ff      <= BREAK_NONE;
         break_threshold_ff <= '0;
         center_ff          <= '0;
         center_label_ff    <= '0;
         center_col_ff      <= '0;
         center_row_ff      <= '0;
         rd_vld_ff          <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= issue;
         rsp_valid_ff <= emit;
         if (take_neighbor) begin
            cnt_ff <= '0;
         end else if (issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BREAK_MODE:      break_mode_ff      <= csr_data[1:0];
               CSR_BREAK_THRESHOLD: break_threshold_ff <= csr_data[30:0];
               default:             ;
            endcase
         end
         if (take_center) begin
            center_ff       <= req_vec;
            center_label_ff <= req_data.region_label;
            center_col_ff   <= req_data.col;
            center_row_ff   <= req_data.row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_neighbor) begin
         dir_ff <= req_data.direction;
         vec_ff <= use_center ? center_ff : req_vec;
      end
      rd_lane_ff <= cnt_ff;
      rd_last_ff <= cnt_ff == LANE_W'(MATRIX_DIM - 1);
      if (emit) begin
         rsp_data_ff.new_z   <= sat32(acc[0]);
         rsp_data_ff.new_a   <= sat32(acc[1]);
         rsp_data_ff.new_b   <= sat32(acc[2]);
         rsp_data_ff.new_c   <= sat32(acc[3]);
         rsp_data_ff.new_d   <= sat32(acc[4]);
         rsp_data_ff.new_e   <= sat32(acc[5]);
         rsp_data_ff.col_out <= center_col_ff;
         rsp_data_ff.row_out <= center_row_ff;
      end
   end

   qsnu_coef_mem u_coef_mem (
      .clock   (clock),
      .wr_en   (take_load),
      .wr_row  (wr_row),
      .wr_col  (wr_col),
      .wr_data (req_data.val_z),
      .rd_en   (issue),
      .rd_row  (rd_row),
      .rd_data (coef_row)
   );

   always_comb begin
      mac_ctrl.valid = rd_vld_ff;
      mac_ctrl.last  = rd_last_ff;
      mac_ctrl.lane  = rd_lane_ff;
      mac_ctrl.clear = take_center | emit;
   end

   qsnu_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .coef_row (coef_row),
      .vec      (vec_ff),
      .acc      (acc),
      .done     (done)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
